/* sv/sorted_fifo_node_queue_assert.svh */
// Assertion macros shared by the checker of the sorted node queue.
// Each macro takes a label, the clock, the active-low reset and the two property sides.
`ifndef SORTED_FIFO_NODE_QUEUE_ASSERT_SVH
`define SORTED_FIFO_NODE_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted node queue check failed");

// Next-cycle implication, checked outside reset.
`define SFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted node queue check failed");

`endif

/* sv/sfq_pkg.sv */
// Package of the sorted node queue: sizes, item types, operation codes and states.
// Used by the top level, the entry RAM user and the checker.
`timescale 1ns / 1ps

package sfq_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_BITS  = 8;
  localparam int KEY_BITS = 32;
  localparam int KIND_W   = 3;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ENT_W    = ID_BITS + KEY_BITS;

  typedef logic [ID_BITS-1:0]         id_t;
  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [IDX_W-1:0]           idx_t;

  typedef struct packed {
    id_t  id;
    key_t key;
  } entry_t;

  localparam cnt_t FULL_CNT = cnt_t'(DEPTH);

  typedef enum logic [KIND_W-1:0] {
    K_APPEND   = 3'd0,
    K_INSERT   = 3'd1,
    K_PEEK     = 3'd2,
    K_DEQ      = 3'd3,
    K_REMOVE   = 3'd4,
    K_CONTAINS = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PUT
  } state_t;

endpackage

/* sv/sfq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the entries of the sorted node queue.
`timescale 1ns / 1ps

module sfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/sorted_fifo_node_queue.sv */
// Sorted node queue: an ordered array of node identifiers with signed keys.
// Depends on sfq_pkg and sfq_ram.
`timescale 1ns / 1ps
//
// Usage: present in_kind, in_node_id and in_key with in_start high; the item
// is taken at a clock edge where in_start is high and busy is low. Each item
// returns exactly one result, shown for one cycle with out_valid high; the
// receiver cannot stall, so it must take the result in that cycle.
// Append, operations on an empty queue, inserts into a full queue and unused
// kinds finish at once: the result appears in the cycle after the item
// is taken and busy stays low, so such items may follow back to back.
// The other operations walk the entry RAM with one compare unit. Each entry
// visited passes through a RAM read state, then a compare and write-back
// state, and the next item can be taken only once the walk has ended;
// busy is high until the result appears. Sorted insert walks from the head
// and, from the first entry with a larger key on, carries each entry up one
// slot, ending with a write at the tail; dequeue and remove walk from the
// head, shifting the later entries down once the leaving entry is passed.
// Synchronous reset empties the queue; the RAM contents are not cleared,
// because only entries below the occupancy are ever read.

module sorted_fifo_node_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_start,
  output logic                   busy,
  input  logic [2:0]             in_kind,
  input  sfq_pkg::id_t           in_node_id,
  input  sfq_pkg::key_t          in_key,
  output logic                   out_valid,
  output logic                   out_status,
  output logic                   out_found,
  output sfq_pkg::id_t           out_head_id,
  output sfq_pkg::key_t          out_head_key,
  output sfq_pkg::cnt_t          out_occupancy
);

  import sfq_pkg::*;

  state_t state_r, state_nxt;
  kind_t  op_r, op_nxt;
  id_t    id_r, id_nxt;
  key_t   key_r, key_nxt;
  cnt_t   cnt_r, cnt_nxt;
  cnt_t   idx_r, idx_nxt;
  logic   hit_r, hit_nxt;
  entry_t head_r, head_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_status_r, out_status_nxt;
  logic   out_found_r, out_found_nxt;
  entry_t out_head_r, out_head_nxt;
  cnt_t   out_occ_r, out_occ_nxt;

  logic   ram_we;
  idx_t   ram_waddr, ram_raddr;
  entry_t ram_wdata, rd_ent, in_ent, new_ent;
  logic [ENT_W-1:0] ram_rdata;

  logic   fin, fin_status, fin_found;
  entry_t fin_head;
  cnt_t   idx_m1, idx_p1;
  logic   full, empty;

  sfq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent  = entry_t'(ram_rdata);
  assign in_ent  = '{id: in_node_id, key: in_key};
  assign new_ent = '{id: id_r, key: key_r};
  assign idx_m1  = idx_r - cnt_t'(1);
  assign idx_p1  = idx_r + cnt_t'(1);
  assign full    = (cnt_r >= FULL_CNT);
  assign empty   = (cnt_r == '0);

  // Every walk moves from the head toward the tail and reads at the index.
  assign ram_raddr = idx_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    head_r       <= head_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_head_r   <= out_head_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    id_nxt     = id_r;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    head_nxt   = head_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = new_ent;
    fin        = 1'b0;
    fin_status = 1'b0;
    fin_found  = 1'b0;
    fin_head   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_start) begin
          op_nxt  = kind_t'(in_kind);
          id_nxt  = in_node_id;
          key_nxt = in_key;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          case (kind_t'(in_kind))
            K_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_status = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[IDX_W-1:0];
                ram_wdata = in_ent;
                cnt_nxt   = cnt_r + cnt_t'(1);
              end
            end
            K_INSERT: begin
              if (full) begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end else if (empty) begin
                fin       = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_ent;
                cnt_nxt   = cnt_r + cnt_t'(1);
              end else begin
                state_nxt = S_READ;
              end
            end
            K_PEEK, K_DEQ, K_REMOVE, K_CONTAINS: begin
              if (empty) begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        state_nxt = S_READ;
        if (idx_r == '0) begin
          head_nxt = rd_ent;
        end
        case (op_r)
          K_INSERT: begin
            // Stable order: the new item takes the slot of the first entry with a larger
            // key, and from there on each entry read is carried one slot up.
            if (hit_r || ($signed(rd_ent.key) > $signed(key_r))) begin
              ram_we    = 1'b1;
              ram_waddr = idx_r[IDX_W-1:0];
              ram_wdata = new_ent;
              id_nxt    = rd_ent.id;
              key_nxt   = rd_ent.key;
              hit_nxt   = 1'b1;
            end
            idx_nxt = idx_p1;
            if (idx_p1 == cnt_r) begin
              state_nxt = S_PUT;
            end
          end
          K_PEEK: begin
            fin      = 1'b1;
            fin_head = rd_ent;
          end
          K_DEQ, K_REMOVE: begin
            // Once the leaving entry is passed, every later entry moves down one slot.
            if (hit_r) begin
              ram_we    = 1'b1;
              ram_waddr = idx_m1[IDX_W-1:0];
              ram_wdata = rd_ent;
            end else if (op_r == K_DEQ || rd_ent.id == id_r) begin
              hit_nxt = 1'b1;
            end
            idx_nxt = idx_p1;
            if (idx_p1 == cnt_r) begin
              fin        = 1'b1;
              fin_status = !hit_nxt;
              if (hit_nxt) begin
                cnt_nxt = cnt_r - cnt_t'(1);
              end
              if (op_r == K_DEQ) begin
                fin_head = head_nxt;
              end
            end
          end
          K_CONTAINS: begin
            idx_nxt = idx_p1;
            if (rd_ent.id == id_r) begin
              fin       = 1'b1;
              fin_found = 1'b1;
            end else if (idx_p1 == cnt_r) begin
              fin = 1'b1;
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = 1'b1;
          end
        endcase
      end

      S_PUT: begin
        // The carried entry, or the new item when nothing was larger, lands at the tail.
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = new_ent;
        cnt_nxt   = cnt_r + cnt_t'(1);
        fin       = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end

    out_valid_nxt  = fin;
    out_status_nxt = fin ? fin_status : out_status_r;
    out_found_nxt  = fin ? fin_found : out_found_r;
    out_head_nxt   = fin ? fin_head : out_head_r;
    out_occ_nxt    = fin ? cnt_nxt : out_occ_r;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_head_id   = out_head_r.id;
  assign out_head_key  = out_head_r.key;
  assign out_occupancy = out_occ_r;

endmodule

/* sv/sfq_checker.sv */
// Port-level checker of the sorted node queue, bound to the top level.
// Depends on sfq_pkg and the assertion macros in sorted_fifo_node_queue_assert.svh.
`timescale 1ns / 1ps
`include "sorted_fifo_node_queue_assert.svh"

module sfq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_start,
  input logic          busy,
  input logic          out_valid,
  input logic          out_status,
  input logic          out_found,
  input sfq_pkg::id_t  out_head_id,
  input sfq_pkg::key_t out_head_key,
  input sfq_pkg::cnt_t out_occupancy
);

  import sfq_pkg::*;

  // An accepted item either finishes at once or keeps the block busy.
  `SFQ_ASSERT_NEXT(a_accept_progress, clk, rst_n, in_start && !busy, busy || out_valid)
  // A result is shown only once the walk is over.
  `SFQ_ASSERT_IMPLY(a_result_idle, clk, rst_n, out_valid, !busy)
  // The occupancy never exceeds the capacity.
  `SFQ_ASSERT_IMPLY(a_occ_bound, clk, rst_n, out_valid, out_occupancy <= FULL_CNT)
  // An error result carries no head entry and no hit.
  `SFQ_ASSERT_IMPLY(a_err_clean, clk, rst_n, out_valid && out_status,
                    out_head_id == '0 && out_head_key == '0 && !out_found)

endmodule

bind sorted_fifo_node_queue sfq_checker u_sfq_checker (.*);
